@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL. They compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RBJ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define RBJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RBJ_ASSERT(lbl, clk, rst_n, prop)
`define RBJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/rbj_pkg.sv @@
package rbj_pkg;

    localparam int unsigned AttemptW = 16;
    localparam int unsigned DelayW   = 13;
    localparam int unsigned DivW     = 12;
    localparam int unsigned SeedW    = 64;
    localparam int unsigned CountW   = 6;

    localparam logic [SeedW-1:0] NormSeed0 = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [SeedW-1:0] FastSeed0 = 64'h2545_f491_4f6c_dd1d;

    localparam logic [DelayW-1:0] DelayMax = 13'd7500;

    localparam logic ModeNormal = 1'b0;
    localparam logic ModeFast   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } rbj_state_t;

    typedef struct packed {
        logic start;
    } rbj_mod_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rbj_mod_sts_t;

    function automatic logic [SeedW-1:0] xorshift64(input logic [SeedW-1:0] s);
        logic [SeedW-1:0] a;
        logic [SeedW-1:0] b;
        a = s ^ (s << 13);
        b = a ^ (a >> 7);
        return b ^ (b << 17);
    endfunction

    // Exponential base with the per-mode shift clamp and cap already applied.
    function automatic logic [DelayW-1:0] base_ms(input logic mode,
                                                  input logic [AttemptW-1:0] attempt);
        logic [DelayW-1:0] base;
        base = 13'd5000;
        if (mode == ModeNormal) begin
            case (attempt)
                16'd0:   base = 13'd100;
                16'd1:   base = 13'd200;
                16'd2:   base = 13'd400;
                16'd3:   base = 13'd800;
                16'd4:   base = 13'd1600;
                16'd5:   base = 13'd3200;
                default: base = 13'd5000;
            endcase
        end else begin
            case (attempt)
                16'd0:   base = 13'd25;
                16'd1:   base = 13'd50;
                16'd2:   base = 13'd100;
                16'd3:   base = 13'd200;
                default: base = 13'd250;
            endcase
        end
        return base;
    endfunction

endpackage

@@ rtl/core/rbj_if.sv @@
interface rbj_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic [rbj_pkg::AttemptW-1:0]          attempt;

    modport source (output valid, output req_type, output attempt, input ready);
    modport sink   (input valid, input req_type, input attempt, output ready);
endinterface

interface rbj_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [rbj_pkg::DelayW-1:0]            delay_ms;

    modport source (output valid, output delay_ms, input ready);
    modport sink   (input valid, input delay_ms, output ready);
endinterface

@@ rtl/core/rbj_mod.sv @@
// Restoring bit-serial remainder: one dividend bit per cycle, one compare and subtract.
module rbj_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rbj_pkg::rbj_mod_ctl_t         ctl,
    input  logic [rbj_pkg::SeedW-1:0]     dividend,
    input  logic [rbj_pkg::DivW-1:0]      divisor,
    output rbj_pkg::rbj_mod_sts_t         sts,
    output logic [rbj_pkg::DivW-1:0]      remainder
);

    logic [rbj_pkg::SeedW-1:0]  dvd_reg, dvd_next;
    logic [rbj_pkg::DivW-1:0]   div_reg, div_next;
    logic [rbj_pkg::DivW-1:0]   rem_reg, rem_next;
    logic [rbj_pkg::CountW-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [rbj_pkg::DivW:0]     trial;
    logic                       last;

    assign trial = {rem_reg, dvd_reg[rbj_pkg::SeedW-1]};
    assign last  = (cnt_reg == {rbj_pkg::CountW{1'b1}});

    always_comb
    begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[rbj_pkg::SeedW-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = rbj_pkg::DivW'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[rbj_pkg::DivW-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/retry_backoff_jitter.sv @@
// Retry backoff with jitter. Each request item carries a mode (0 normal, 1 fast) and an
// attempt count, and yields one delay_ms item: the clamped exponential base plus a jitter
// equal to the mode's freshly advanced xorshift64 seed modulo (base/2 + 1). After acceptance
// the remainder unit retires one of the 64 seed bits per cycle; its done flag is registered,
// and in the cycle it is seen the output register is loaded if it is free, else the item
// waits in the hold state. The request side is ready only while no item is being worked,
// so a new item is not accepted until the last one's result is in the output register. A finished
// result waits in the output register, and a new request may be accepted while it waits.
`include "assert_macros.svh"

module retry_backoff_jitter (
    input  logic        clk,
    input  logic        rst_n,
    rbj_req_if.sink     req,
    rbj_rsp_if.source   rsp
);

    rbj_pkg::rbj_state_t          state_reg, state_next;
    logic [rbj_pkg::SeedW-1:0]    seed0_reg, seed0_next;
    logic [rbj_pkg::SeedW-1:0]    seed1_reg, seed1_next;
    logic [rbj_pkg::DelayW-1:0]   base_reg, base_next;
    logic [rbj_pkg::DelayW-1:0]   delay_reg, delay_next;
    logic                         out_valid_reg, out_valid_next;

    logic                         accept;
    logic                         out_free;
    logic                         load;
    logic [rbj_pkg::SeedW-1:0]    seed_cur;
    logic [rbj_pkg::SeedW-1:0]    seed_adv;
    logic [rbj_pkg::DelayW-1:0]   base_in;
    logic [rbj_pkg::DivW-1:0]     divisor;

    rbj_pkg::rbj_mod_ctl_t        mod_ctl;
    rbj_pkg::rbj_mod_sts_t        mod_sts;
    logic [rbj_pkg::DivW-1:0]     mod_rem;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // A zero seed only occurs before a mode's first request.
    always_comb
    begin
        if (req.req_type == rbj_pkg::ModeFast) begin
            seed_cur = (seed1_reg == '0) ? rbj_pkg::FastSeed0 : seed1_reg;
        end else begin
            seed_cur = (seed0_reg == '0) ? rbj_pkg::NormSeed0 : seed0_reg;
        end
    end

    assign seed_adv = rbj_pkg::xorshift64(seed_cur);
    assign base_in  = rbj_pkg::base_ms(req.req_type, req.attempt);
    assign divisor  = base_in[rbj_pkg::DelayW-1:1] + 1'b1;

    assign mod_ctl.start = accept;

    rbj_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mod_ctl),
        .dividend  (seed_adv),
        .divisor   (divisor),
        .sts       (mod_sts),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        load           = 1'b0;
        seed0_next     = seed0_reg;
        seed1_next     = seed1_reg;
        base_next      = base_reg;
        req.ready      = 1'b0;
        unique case (state_reg)
            rbj_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid) begin
                    base_next = base_in;
                    if (req.req_type == rbj_pkg::ModeFast) begin
                        seed1_next = seed_adv;
                    end else begin
                        seed0_next = seed_adv;
                    end
                    state_next = rbj_pkg::ST_BUSY;
                end
            end
            rbj_pkg::ST_BUSY:
            begin
                if (mod_sts.done) begin
                    if (out_free) begin
                        load       = 1'b1;
                        state_next = rbj_pkg::ST_IDLE;
                    end else begin
                        state_next = rbj_pkg::ST_HOLD;
                    end
                end
            end
            rbj_pkg::ST_HOLD:
            begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = rbj_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbj_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        delay_next     = delay_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            delay_next     = base_reg + {1'b0, mod_rem};
            out_valid_next = 1'b1;
        end else if (rsp.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= rbj_pkg::ST_IDLE;
            seed0_reg     <= '0;
            seed1_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seed0_reg     <= seed0_next;
            seed1_reg     <= seed1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        delay_reg <= delay_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.delay_ms = delay_reg;

    `RBJ_ASSERT(a_ready_unit_idle, clk, rst_n, !req.ready || !mod_sts.busy)
    `RBJ_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, mod_sts.busy)
    `RBJ_ASSERT(a_done_in_busy, clk, rst_n, !mod_sts.done || state_reg == rbj_pkg::ST_BUSY)
    `RBJ_ASSERT(a_rem_bound, clk, rst_n, !mod_sts.done || mod_rem <= rbj_pkg::DivW'(base_reg >> 1))
    `RBJ_ASSERT(a_delay_range, clk, rst_n, !rsp.valid || rsp.delay_ms <= rbj_pkg::DelayMax)

endmodule

@@ tb/testbench.sv @@
module testbench;
    import rbj_pkg::*;

    localparam int unsigned IdlePct    = 14;
    localparam int unsigned LongHold   = 500;
    localparam int unsigned SettleWait = 100;
    localparam int unsigned StuckLimit = 3000;

    logic clk = 1'b0;
    logic rst_n;

    rbj_req_if req_ch ();
    rbj_rsp_if rsp_ch ();

    retry_backoff_jitter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    logic [SeedW-1:0]  jitter_seed [2];
    logic [DelayW-1:0] pending_delays [$];
    logic [DelayW-1:0] want_delay;
    int unsigned       n_req;
    int unsigned       n_rsp;
    int unsigned       n_errors;
    int unsigned       stuck_cycles;
    bit                no_idle;
    int unsigned       hold_token;
    int unsigned       hold_seen;
    int unsigned       hold_left;

    // Advances the seed of the requested mode and returns the delay it yields.
    function automatic logic [DelayW-1:0] predict_delay(input logic mode,
                                                       input logic [AttemptW-1:0] att);
        int unsigned      unit_ms;
        int unsigned      cap_ms;
        int unsigned      max_sh;
        int unsigned      sh;
        int unsigned      base;
        logic [SeedW-1:0] s;
        if (mode == ModeNormal) begin
            unit_ms = 100;
            cap_ms  = 5000;
            max_sh  = 6;
            s       = jitter_seed[0];
            if (s == '0)
                s = NormSeed0;
        end else begin
            unit_ms = 25;
            cap_ms  = 250;
            max_sh  = 4;
            s       = jitter_seed[1];
            if (s == '0)
                s = FastSeed0;
        end
        sh   = (att < max_sh) ? att : max_sh;
        base = unit_ms << sh;
        if (base > cap_ms)
            base = cap_ms;
        s = s ^ (s << 13);
        s = s ^ (s >> 7);
        s = s ^ (s << 17);
        jitter_seed[mode] = s;
        return DelayW'(base + 32'(s % 64'(base / 2 + 1)));
    endfunction

    // Mostly attempts around the clamp, with some spread over the whole field.
    function automatic logic [AttemptW-1:0] pick_attempt();
        logic [AttemptW-1:0] a;
        case ($urandom_range(3))
            0, 1:    a = AttemptW'($urandom_range(8));
            2:       a = AttemptW'($urandom_range(65535));
            default: a = AttemptW'(1) << $urandom_range(AttemptW - 1);
        endcase
        return a;
    endfunction

    // Request and result monitor, expected-delay scoreboard and watchdog.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (req_ch.valid && req_ch.ready) begin
                pending_delays.push_back(predict_delay(req_ch.req_type, req_ch.attempt));
                n_req <= n_req + 1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_rsp <= n_rsp + 1;
                if (pending_delays.size() == 0) begin
                    $display("%0t: delay_ms expected none, actual %0d", $time,
                             rsp_ch.delay_ms);
                    n_errors <= n_errors + 1;
                end else begin
                    want_delay = pending_delays.pop_front();
                    if (rsp_ch.delay_ms !== want_delay) begin
                        $display("%0t: delay_ms expected %0d, actual %0d", $time,
                                 want_delay, rsp_ch.delay_ms);
                        n_errors <= n_errors + 1;
                    end
                end
            end
            if (stuck_cycles >= StuckLimit) begin
                $display("%0t: no item moved for %0d cycles", $time, stuck_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result receiver: random stalls, a quiet mode, and a long counted hold-off on request.
    always @(posedge clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= LongHold - 1;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (no_idle) begin
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IdlePct);
        end
    end

    // Valid is left high after an item so that back-to-back items need no toggle.
    task automatic offer_request(input logic mode, input logic [AttemptW-1:0] att);
        if (!no_idle && $urandom_range(99) < IdlePct) begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IdlePct);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= mode;
        req_ch.attempt  <= att;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic wait_for_delays();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_delays.size() != 0);
    endtask

    // Both seeds start from zero, so the first item of each mode uses the default seed.
    task automatic test_directed_cases();
        int unsigned k;
        offer_request(ModeNormal, 16'd0);
        offer_request(ModeFast, 16'd0);
        for (k = 1; k <= 7; k++)
            offer_request(ModeNormal, AttemptW'(k));
        for (k = 1; k <= 5; k++)
            offer_request(ModeFast, AttemptW'(k));
        offer_request(ModeNormal, 16'hFFFF);
        offer_request(ModeNormal, 16'h8000);
        offer_request(ModeNormal, 16'h5555);
        offer_request(ModeFast, 16'hFFFF);
        offer_request(ModeFast, 16'h5555);
        offer_request(ModeFast, 16'hAAAA);
        wait_for_delays();
    endtask

    // Long runs of one mode must leave the other mode's seed untouched.
    task automatic test_mode_isolation();
        int unsigned k;
        for (k = 0; k < 15; k++)
            offer_request(ModeNormal, pick_attempt());
        for (k = 0; k < 15; k++)
            offer_request(ModeFast, pick_attempt());
        for (k = 0; k < 10; k++)
            offer_request(ModeNormal, pick_attempt());
        wait_for_delays();
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++)
            offer_request(logic'($urandom_range(1)), pick_attempt());
        wait_for_delays();
    endtask

    task automatic test_back_to_back();
        int unsigned k;
        no_idle = 1'b1;
        for (k = 0; k < 60; k++)
            offer_request(logic'($urandom_range(1)), pick_attempt());
        wait_for_delays();
        no_idle = 1'b0;
    endtask

    // The receiver stalls for a long stretch while items keep coming, so the input stalls.
    task automatic test_output_stall();
        int unsigned k;
        hold_token = hold_token + 1;
        for (k = 0; k < 20; k++)
            offer_request(logic'($urandom_range(1)), pick_attempt());
        wait_for_delays();
    endtask

    initial begin
        jitter_seed[0]  = '0;
        jitter_seed[1]  = '0;
        n_req           = 0;
        n_rsp           = 0;
        n_errors        = 0;
        stuck_cycles    = 0;
        no_idle         = 1'b0;
        hold_token      = 0;
        hold_seen       = 0;
        hold_left       = 0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = ModeNormal;
        req_ch.attempt  = '0;
        rsp_ch.ready    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_mode_isolation();
        test_random_traffic(150);
        test_output_stall();
        test_back_to_back();
        test_random_traffic(160);

        repeat (SettleWait) @(posedge clk);
        $display("Ran %0d requests and checked %0d delays over both modes and wide attempts,",
                 n_req, n_rsp);
        $display("with random gaps, back-to-back items and a long output stall.");
        if (n_errors == 0 && pending_delays.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
